// ===== rtl/frwl_pkg.sv =====
// Shared constants, codes and controller/datapath handshake types for the FIFO reader-writer lock.
package frwl_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = PTR_W + 1;
  localparam int ID_W        = 16;
  localparam int HOLD_W      = 8;
  localparam int STAT_W      = 3;
  localparam int MAX_HOLDERS = 255;
  localparam int MAX_GRANTS  = 16;

  localparam logic [STAT_W-1:0] STAT_ACQUIRED = 3'd0;
  localparam logic [STAT_W-1:0] STAT_QUEUED   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_RELEASED = 3'd2;
  localparam logic [STAT_W-1:0] STAT_GRANTED  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd4;
  localparam logic [STAT_W-1:0] STAT_BADREL   = 3'd5;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 3'd6;

  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_SCAN,
    CTL_GRANT
  } ctl_state_t;

  typedef struct packed {
    logic load_in;     // capture an input transfer into the request buffer
    logic step;        // resolve a single-result request
    logic start_scan;  // begin measuring the run of waiters to grant
    logic scan_adv;    // extend the run by one waiter
    logic commit;      // apply the run to the lock state
    logic emit;        // send one grant result
  } dp_cmd_t;

  typedef struct packed {
    logic walk;        // buffered request is a last release with waiters queued
    logic scan_stop;   // run of waiters is complete
    logic emit_last;   // current grant is the final one of the run
  } dp_stat_t;

endpackage

// ===== rtl/fifo_reader_writer_lock.sv =====
// Top level of the FIFO reader-writer lock: controller plus datapath.
//
// Input channel (in_valid / in_stall): one request per transfer, an acquire or
// a release with its access mode and requester id. A one-entry request buffer
// takes a transfer whenever it is empty, so a request can arrive while a
// result still waits at the output.
// Output channel (out_valid / out_stall): one or more results per request;
// last_result marks the final one. holder_count, lock_held and waiter_count
// always report the state after the whole request.
// A transferred request passes from the request buffer to the result register
// when the output is free. The request buffer takes no new transfer while it
// holds a request, so single-result requests are handed off one at a time.
// A last release with waiters first measures the run R of granted waiters (one
// waiter checked per cycle against the mode store), commits it, then gives one
// grant per cycle while the output is free; R is at most 16.
// A stalled output holds its result; the block then holds further work, and
// the request buffer stalls the input once full.
// Reset (rst, synchronous) empties the lock and the queue and drops buffered
// requests and pending results; the waiter store itself is not cleared.
module fifo_reader_writer_lock (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              req_type,
  input  logic                              access_mode,
  input  logic [frwl_pkg::ID_W-1:0]         requester_id,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [frwl_pkg::STAT_W-1:0]       status,
  output logic [frwl_pkg::ID_W-1:0]         granted_id,
  output logic                              granted_mode,
  output logic                              last_result,
  output logic [frwl_pkg::HOLD_W-1:0]       holder_count,
  output logic                              lock_held,
  output logic [frwl_pkg::CNT_W-1:0]        waiter_count
);

  frwl_pkg::dp_cmd_t  cmd;
  frwl_pkg::dp_stat_t stat;

  frwl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  frwl_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_type     (req_type),
    .access_mode  (access_mode),
    .requester_id (requester_id),
    .status       (status),
    .granted_id   (granted_id),
    .granted_mode (granted_mode),
    .last_result  (last_result),
    .holder_count (holder_count),
    .lock_held    (lock_held),
    .waiter_count (waiter_count)
  );

endmodule

// ===== rtl/frwl_datapath.sv =====
// Datapath: request buffer, lock state, waiter queue, grant run counter and result register.
module frwl_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  frwl_pkg::dp_cmd_t                 cmd,
  output frwl_pkg::dp_stat_t                stat,
  input  logic                              req_type,
  input  logic                              access_mode,
  input  logic [frwl_pkg::ID_W-1:0]         requester_id,
  output logic [frwl_pkg::STAT_W-1:0]       status,
  output logic [frwl_pkg::ID_W-1:0]         granted_id,
  output logic                              granted_mode,
  output logic                              last_result,
  output logic [frwl_pkg::HOLD_W-1:0]       holder_count,
  output logic                              lock_held,
  output logic [frwl_pkg::CNT_W-1:0]        waiter_count
);

  localparam logic [frwl_pkg::HOLD_W-1:0] HOLD_ONE  = frwl_pkg::HOLD_W'(1);
  localparam logic [frwl_pkg::HOLD_W-1:0] HOLD_MAX  = frwl_pkg::HOLD_W'(frwl_pkg::MAX_HOLDERS);
  localparam logic [frwl_pkg::CNT_W-1:0]  FILL_ONE  = frwl_pkg::CNT_W'(1);
  localparam logic [frwl_pkg::CNT_W-1:0]  FILL_FULL = frwl_pkg::CNT_W'(frwl_pkg::QUEUE_DEPTH);
  localparam logic [frwl_pkg::CNT_W-1:0]  GRANT_MAX = frwl_pkg::CNT_W'(frwl_pkg::MAX_GRANTS);

  // request buffer
  logic                          req_r;
  logic                          mode_r;
  logic [frwl_pkg::ID_W-1:0]     id_r;

  // lock state
  logic [frwl_pkg::HOLD_W-1:0]   holders;
  logic                          held_mode;
  logic [frwl_pkg::PTR_W-1:0]    head;
  logic [frwl_pkg::PTR_W-1:0]    tail;
  logic [frwl_pkg::CNT_W-1:0]    fill;
  logic [frwl_pkg::ID_W-1:0]     waiter_ids   [frwl_pkg::QUEUE_DEPTH];
  logic                          waiter_modes [frwl_pkg::QUEUE_DEPTH];

  // grant run
  logic [frwl_pkg::CNT_W-1:0]    run_cnt;
  logic [frwl_pkg::PTR_W-1:0]    emit_ptr;
  logic                          first_mode;

  // single-result resolution
  logic [frwl_pkg::HOLD_W-1:0]   holders_next;
  logic                          held_mode_next;
  logic [frwl_pkg::CNT_W-1:0]    fill_next;
  logic                          enq;
  logic [frwl_pkg::STAT_W-1:0]   res_status;
  logic [frwl_pkg::ID_W-1:0]     res_id;
  logic                          res_mode;
  logic [frwl_pkg::PTR_W-1:0]    scan_idx;

  always_comb begin
    holders_next   = holders;
    held_mode_next = held_mode;
    fill_next      = fill;
    enq            = 1'b0;
    res_status     = frwl_pkg::STAT_BADREL;
    res_id         = '0;
    res_mode       = 1'b0;
    if (req_r == frwl_pkg::REQ_ACQUIRE) begin
      if (holders == '0) begin
        holders_next   = HOLD_ONE;
        held_mode_next = mode_r;
        res_status     = frwl_pkg::STAT_ACQUIRED;
        res_id         = id_r;
        res_mode       = mode_r;
      end else if (mode_r == frwl_pkg::MODE_READ && held_mode == frwl_pkg::MODE_READ &&
                   fill == '0) begin
        if (holders >= HOLD_MAX) begin
          res_status = frwl_pkg::STAT_OVERFLOW;
        end else begin
          holders_next = holders + HOLD_ONE;
          res_status   = frwl_pkg::STAT_ACQUIRED;
          res_id       = id_r;
          res_mode     = mode_r;
        end
      end else if (fill >= FILL_FULL) begin
        res_status = frwl_pkg::STAT_FULL;
      end else begin
        enq        = 1'b1;
        fill_next  = fill + FILL_ONE;
        res_status = frwl_pkg::STAT_QUEUED;
      end
    end else begin
      if (holders == '0 || mode_r != held_mode) begin
        res_status = frwl_pkg::STAT_BADREL;
      end else if (holders > HOLD_ONE) begin
        holders_next = holders - HOLD_ONE;
        res_status   = frwl_pkg::STAT_RELEASED;
      end else begin
        // last holder with an empty queue; the non-empty case walks instead
        holders_next   = '0;
        held_mode_next = 1'b0;
        res_status     = frwl_pkg::STAT_RELEASED;
      end
    end
  end

  assign scan_idx = head + run_cnt[frwl_pkg::PTR_W-1:0];

  assign stat.walk = (req_r == frwl_pkg::REQ_RELEASE) && (holders == HOLD_ONE) &&
                     (mode_r == held_mode) && (fill != '0);
  assign stat.scan_stop = (first_mode == frwl_pkg::MODE_WRITE) || (run_cnt == fill) ||
                          (run_cnt >= GRANT_MAX) ||
                          (frwl_pkg::HOLD_W'(run_cnt) >= HOLD_MAX) ||
                          (waiter_modes[scan_idx] != frwl_pkg::MODE_READ);
  assign stat.emit_last = (run_cnt == FILL_ONE);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r  <= req_type;
      mode_r <= access_mode;
      id_r   <= requester_id;
    end
    if (cmd.step && enq) begin
      waiter_ids[tail]   <= id_r;
      waiter_modes[tail] <= mode_r;
    end
    if (cmd.start_scan) begin
      first_mode <= waiter_modes[head];
      emit_ptr   <= head;
      run_cnt    <= FILL_ONE;
    end else if (cmd.scan_adv) begin
      run_cnt <= run_cnt + FILL_ONE;
    end else if (cmd.emit) begin
      run_cnt  <= run_cnt - FILL_ONE;
      emit_ptr <= emit_ptr + frwl_pkg::PTR_W'(1);
    end
    // result register
    if (cmd.step) begin
      status       <= res_status;
      granted_id   <= res_id;
      granted_mode <= res_mode;
      last_result  <= 1'b1;
      holder_count <= holders_next;
      lock_held    <= (holders_next != '0);
      waiter_count <= fill_next;
    end else if (cmd.emit) begin
      status       <= frwl_pkg::STAT_GRANTED;
      granted_id   <= waiter_ids[emit_ptr];
      granted_mode <= first_mode;
      last_result  <= stat.emit_last;
      holder_count <= holders;
      lock_held    <= (holders != '0);
      waiter_count <= fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holders   <= '0;
      held_mode <= 1'b0;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
    end else if (cmd.step) begin
      holders   <= holders_next;
      held_mode <= held_mode_next;
      fill      <= fill_next;
      if (enq) begin
        tail <= tail + frwl_pkg::PTR_W'(1);
      end
    end else if (cmd.commit) begin
      // hand the lock to the whole run at once; grants are reported afterwards
      holders   <= frwl_pkg::HOLD_W'(run_cnt);
      held_mode <= first_mode;
      head      <= head + run_cnt[frwl_pkg::PTR_W-1:0];
      fill      <= fill - run_cnt;
    end
  end

endmodule

// ===== rtl/frwl_ctrl.sv =====
// Controller: request buffer and result valid flags, and the sequencing of grant runs.
module frwl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output frwl_pkg::dp_cmd_t  cmd,
  input  frwl_pkg::dp_stat_t stat
);

  frwl_pkg::ctl_state_t state, state_next;
  logic                 buf_valid;
  logic                 out_free;
  logic                 load_out;

  assign in_stall = buf_valid;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      frwl_pkg::CTL_IDLE: begin
        if (buf_valid && out_free && stat.walk) begin
          state_next = frwl_pkg::CTL_SCAN;
        end
      end
      frwl_pkg::CTL_SCAN: begin
        if (stat.scan_stop) begin
          state_next = frwl_pkg::CTL_GRANT;
        end
      end
      frwl_pkg::CTL_GRANT: begin
        if (out_free && stat.emit_last) begin
          state_next = frwl_pkg::CTL_IDLE;
        end
      end
      default: state_next = frwl_pkg::CTL_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.load_in = in_valid && !buf_valid;
    unique case (state)
      frwl_pkg::CTL_IDLE: begin
        if (buf_valid && out_free) begin
          cmd.step       = !stat.walk;
          cmd.start_scan = stat.walk;
        end
      end
      frwl_pkg::CTL_SCAN: begin
        cmd.scan_adv = !stat.scan_stop;
        cmd.commit   = stat.scan_stop;
      end
      frwl_pkg::CTL_GRANT: begin
        cmd.emit = out_free;
      end
      default: ;
    endcase
  end

  assign load_out = cmd.step || cmd.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= frwl_pkg::CTL_IDLE;
      buf_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // the request is consumed once resolved or once its run starts
      if (cmd.step || cmd.start_scan) begin
        buf_valid <= 1'b0;
      end else if (cmd.load_in) begin
        buf_valid <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== tb/fifo_reader_writer_lock_test.sv =====
// Self-checking testbench for the FIFO reader-writer lock, with a shadow lock as scoreboard.
`timescale 1ns / 100ps

module fifo_reader_writer_lock_test;
  import frwl_pkg::*;

  localparam int RANDOM_ITEMS = 150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 40;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   granted_id;
    logic              granted_mode;
    logic              last_result;
    logic [HOLD_W-1:0] holder_count;
    logic              lock_held;
    logic [CNT_W-1:0]  waiter_count;
  } lock_reply_t;

  // Shadow copy of the lock: predicts the replies of each accepted request
  class lock_shadow;
    int unsigned holders;
    bit          held_read;
    logic [ID_W-1:0] waiter_ids [QUEUE_DEPTH];
    bit          waiter_read [QUEUE_DEPTH];
    int unsigned head;
    int unsigned tail;
    int unsigned fill;
    lock_reply_t lock_replies[$];
    int          errors;

    function new();
      holders   = 0;
      held_read = 0;
      head      = 0;
      tail      = 0;
      fill      = 0;
      errors    = 0;
    endfunction

    function int pending();
      return lock_replies.size();
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
      errors++;
    endtask

    function void take_request(bit rel, bit mode, logic [ID_W-1:0] id);
      lock_reply_t step_q[$];
      lock_reply_t r;
      bit          first_read;
      bit          more;
      r = '0;
      if (rel == REQ_ACQUIRE) begin
        if (holders == 0) begin
          holders = 1;
          held_read = mode;
          r.status = STAT_ACQUIRED;
          r.granted_id = id;
          r.granted_mode = mode;
        end else if (mode == MODE_READ && held_read && fill == 0) begin
          if (holders >= MAX_HOLDERS) begin
            r.status = STAT_OVERFLOW;
          end else begin
            holders++;
            r.status = STAT_ACQUIRED;
            r.granted_id = id;
            r.granted_mode = mode;
          end
        end else if (fill >= QUEUE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          waiter_ids[tail] = id;
          waiter_read[tail] = mode;
          tail = (tail + 1) % QUEUE_DEPTH;
          fill++;
          r.status = STAT_QUEUED;
        end
        step_q.push_back(r);
      end else if (holders == 0 || mode != held_read) begin
        r.status = STAT_BADREL;
        step_q.push_back(r);
      end else if (holders > 1) begin
        holders--;
        r.status = STAT_RELEASED;
        step_q.push_back(r);
      end else if (fill == 0) begin
        holders = 0;
        held_read = 0;
        r.status = STAT_RELEASED;
        step_q.push_back(r);
      end else begin
        // Hand the lock to the head waiter plus the run of readers behind it
        first_read = waiter_read[head];
        holders = 0;
        held_read = first_read;
        more = 1;
        while (more) begin
          r = '0;
          r.status = STAT_GRANTED;
          r.granted_id = waiter_ids[head];
          r.granted_mode = waiter_read[head];
          step_q.push_back(r);
          head = (head + 1) % QUEUE_DEPTH;
          fill--;
          holders++;
          more = first_read && fill != 0 && step_q.size() < MAX_GRANTS &&
                 holders < MAX_HOLDERS && waiter_read[head] == MODE_READ;
        end
      end
      foreach (step_q[k]) begin
        step_q[k].last_result  = (k == step_q.size() - 1);
        step_q[k].holder_count = holders[HOLD_W-1:0];
        step_q[k].lock_held    = (holders != 0);
        step_q[k].waiter_count = fill[CNT_W-1:0];
        lock_replies.push_back(step_q[k]);
      end
    endfunction

    task check_reply(lock_reply_t got);
      lock_reply_t want;
      if (lock_replies.size() == 0) begin
        report_mismatch("unexpected reply", got.status, 0);
      end else begin
        want = lock_replies.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
        if (got.granted_id !== want.granted_id)
          report_mismatch("granted_id", got.granted_id, want.granted_id);
        if (got.granted_mode !== want.granted_mode)
          report_mismatch("granted_mode", got.granted_mode, want.granted_mode);
        if (got.last_result !== want.last_result)
          report_mismatch("last_result", got.last_result, want.last_result);
        if (got.holder_count !== want.holder_count)
          report_mismatch("holder_count", got.holder_count, want.holder_count);
        if (got.lock_held !== want.lock_held)
          report_mismatch("lock_held", got.lock_held, want.lock_held);
        if (got.waiter_count !== want.waiter_count)
          report_mismatch("waiter_count", got.waiter_count, want.waiter_count);
      end
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              req_type;
  logic              access_mode;
  logic [ID_W-1:0]   requester_id;
  logic              out_valid;
  logic              out_stall;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   granted_id;
  logic              granted_mode;
  logic              last_result;
  logic [HOLD_W-1:0] holder_count;
  logic              lock_held;
  logic [CNT_W-1:0]  waiter_count;

  lock_shadow shadow;
  bit         calm;
  int         cycles;

  fifo_reader_writer_lock i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .access_mode  (access_mode),
    .requester_id (requester_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .granted_id   (granted_id),
    .granted_mode (granted_mode),
    .last_result  (last_result),
    .holder_count (holder_count),
    .lock_held    (lock_held),
    .waiter_count (waiter_count)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("fifo_reader_writer_lock test failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 22);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      shadow.check_reply({status, granted_id, granted_mode, last_result,
                          holder_count, lock_held, waiter_count});
  end

  function automatic logic [ID_W-1:0] rand_id();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      default: return ID_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Present one request and hold it until the transfer
  task automatic send_req(bit rel, bit mode, logic [ID_W-1:0] id);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 22) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    req_type     = rel;
    access_mode  = mode;
    requester_id = id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.take_request(rel, mode, id);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (shadow.pending() != 0) @(negedge clk);
  endtask

  // Release with the held mode until the lock and its queue are empty
  task automatic drain_lock();
    while (shadow.holders != 0) send_req(REQ_RELEASE, shadow.held_read, rand_id());
  endtask

  initial begin
    int p_acq;
    int p_read;
    bit rel;
    bit mode;
    shadow       = new();
    cycles       = 0;
    calm         = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    req_type     = REQ_ACQUIRE;
    access_mode  = MODE_WRITE;
    requester_id = '0;
    out_stall    = 1'b0;
    p_acq        = 50;
    p_read       = 50;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: free lock, bad releases, queueing and grant runs
    send_req(REQ_ACQUIRE, MODE_WRITE, 16'h0000);
    send_req(REQ_RELEASE, MODE_WRITE, rand_id());
    send_req(REQ_RELEASE, MODE_READ,  rand_id());
    send_req(REQ_ACQUIRE, MODE_READ,  16'hFFFF);
    send_req(REQ_ACQUIRE, MODE_READ,  16'h1234);
    send_req(REQ_RELEASE, MODE_WRITE, rand_id());
    send_req(REQ_ACQUIRE, MODE_WRITE, 16'hAAAA);
    send_req(REQ_ACQUIRE, MODE_READ,  16'h5555);
    send_req(REQ_RELEASE, MODE_READ,  rand_id());
    send_req(REQ_RELEASE, MODE_READ,  rand_id());
    send_req(REQ_ACQUIRE, MODE_READ,  16'h0F0F);
    send_req(REQ_ACQUIRE, MODE_READ,  16'hF0F0);
    send_req(REQ_ACQUIRE, MODE_WRITE, 16'h8001);
    send_req(REQ_ACQUIRE, MODE_READ,  16'h7FFE);
    send_req(REQ_RELEASE, MODE_WRITE, rand_id());
    drain_lock();
    wait_drained();

    // Readers up to the holder cap, then one more, then a full queue
    calm = 1'b1;
    repeat (MAX_HOLDERS + 1) send_req(REQ_ACQUIRE, MODE_READ, rand_id());
    send_req(REQ_ACQUIRE, MODE_WRITE, rand_id());
    send_req(REQ_ACQUIRE, MODE_READ, rand_id());
    repeat (MAX_HOLDERS) send_req(REQ_RELEASE, MODE_READ, rand_id());
    repeat (QUEUE_DEPTH) send_req(REQ_ACQUIRE, 1'($urandom_range(0, 1)), rand_id());
    drain_lock();
    calm = 1'b0;
    wait_drained();

    // Random: mostly well-formed traffic in segments of varying bias
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       p_acq = 20;
          1:       p_acq = 50;
          default: p_acq = 85;
        endcase
        case ($urandom_range(0, 2))
          0:       p_read = 20;
          1:       p_read = 50;
          default: p_read = 90;
        endcase
        if (n != 0 && $urandom_range(0, 2) == 0) wait_drained();
      end
      calm = (n >= 40 && n < 110);
      if ($urandom_range(0, 99) < 12) begin
        rel  = 1'($urandom_range(0, 1));
        mode = 1'($urandom_range(0, 1));
      end else if (shadow.holders == 0 || $urandom_range(0, 99) < p_acq) begin
        rel  = REQ_ACQUIRE;
        mode = ($urandom_range(0, 99) < p_read) ? MODE_READ : MODE_WRITE;
      end else begin
        rel  = REQ_RELEASE;
        mode = shadow.held_read;
      end
      send_req(rel, mode, rand_id());
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid = 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("fifo_reader_writer_lock test passed");
    end else begin
      $display("fifo_reader_writer_lock test failed");
    end
    $finish;
  end

endmodule
